@@ rtl/core/mpe_pkg.sv @@
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types and MessagePack format codes for the value encoder.
// ----------------------------------------------------------------------------
package mpe_pkg;

	typedef enum logic [3:0] {
		KIND_NIL   = 4'd0,
		KIND_BOOL  = 4'd1,
		KIND_UINT  = 4'd2,
		KIND_INT   = 4'd3,
		KIND_F32   = 4'd4,
		KIND_F64   = 4'd5,
		KIND_STR   = 4'd6,
		KIND_ARRAY = 4'd7,
		KIND_MAP   = 4'd8,
		KIND_RAW   = 4'd9
	} kind_t;

	localparam logic [7:0] FMT_NIL     = 8'hc0;
	localparam logic [7:0] FMT_FALSE   = 8'hc2;
	localparam logic [7:0] FMT_TRUE    = 8'hc3;
	localparam logic [7:0] FMT_F32     = 8'hca;
	localparam logic [7:0] FMT_F64     = 8'hcb;
	localparam logic [7:0] FMT_UINT8   = 8'hcc;
	localparam logic [7:0] FMT_UINT16  = 8'hcd;
	localparam logic [7:0] FMT_UINT32  = 8'hce;
	localparam logic [7:0] FMT_UINT64  = 8'hcf;
	localparam logic [7:0] FMT_INT8    = 8'hd0;
	localparam logic [7:0] FMT_INT16   = 8'hd1;
	localparam logic [7:0] FMT_INT32   = 8'hd2;
	localparam logic [7:0] FMT_INT64   = 8'hd3;
	localparam logic [7:0] FMT_STR8    = 8'hd9;
	localparam logic [7:0] FMT_STR16   = 8'hda;
	localparam logic [7:0] FMT_STR32   = 8'hdb;
	localparam logic [7:0] FMT_ARRAY16 = 8'hdc;
	localparam logic [7:0] FMT_ARRAY32 = 8'hdd;
	localparam logic [7:0] FMT_MAP16   = 8'hde;
	localparam logic [7:0] FMT_MAP32   = 8'hdf;
	localparam logic [2:0] FIXSTR_BASE = 3'b101;
	localparam logic [3:0] FIXARR_BASE = 4'b1001;
	localparam logic [3:0] FIXMAP_BASE = 4'b1000;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// One encoding job: the format byte, the number of payload bytes that
	// follow it and the payload aligned to the most significant end.
	typedef struct packed {
		logic [7:0]  head;
		logic [3:0]  nbytes;
		logic [63:0] payload;
	} cmd_t;

endpackage

@@ rtl/core/msgpack_value_encoder_core.sv @@
// ----------------------------------------------------------------------------
// msgpack_value_encoder_core
// MessagePack encoder for a single typed value per input beat.
// ----------------------------------------------------------------------------
// Each input beat carries a kind in s_tuser and a 64-bit operand in s_tdata;
// the block sends its MessagePack encoding as 1 to 9 output beats, one byte
// each in wire order, with m_tlast on the final byte. Integers take their
// smallest form, and headers for str, array and map are sized by the length.
// Unused kinds are accepted and produce nothing. The byte serialiser sets the
// rate: one byte per cycle while m_tready is high, so an item holds the output
// until all its bytes are sent. Input beats are taken every cycle while the
// four-entry job queue has room, and each item's first byte passes through
// the job queue and then the registered output stage.
module msgpack_value_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // value[63:0]
	input  logic [3:0]  s_tuser,  // kind[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic        m_tlast
);

	mpe_pkg::cmd_t front_cmd;
	mpe_pkg::cmd_t q_cmd;
	logic          front_valid;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;
	logic          q_push;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && front_valid;

	mpe_front u_front (
		.kind      (s_tuser),
		.value     (s_tdata),
		.cmd_valid (front_valid),
		.cmd       (front_cmd)
	);

	mpe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.pop_cmd  (q_cmd)
	);

	mpe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/core/mpe_front.sv @@
// ----------------------------------------------------------------------------
// mpe_front
// Classifies one value and picks its MessagePack format and payload length.
// ----------------------------------------------------------------------------
module mpe_front (
	input  logic [3:0]    kind,
	input  logic [63:0]   value,
	output logic          cmd_valid,
	output mpe_pkg::cmd_t cmd
);

	logic [31:0] len;

	assign len = value[31:0];

	always_comb begin
		cmd_valid   = 1'b1;
		cmd.head    = mpe_pkg::FMT_NIL;
		cmd.nbytes  = 4'd0;
		cmd.payload = 64'd0;
		case (kind)
			mpe_pkg::KIND_NIL: begin
				cmd.head = mpe_pkg::FMT_NIL;
			end
			mpe_pkg::KIND_BOOL: begin
				cmd.head = (value != 64'd0) ? mpe_pkg::FMT_TRUE : mpe_pkg::FMT_FALSE;
			end
			mpe_pkg::KIND_UINT, mpe_pkg::KIND_INT: begin
				if (kind == mpe_pkg::KIND_INT && value[63]) begin
					if (&value[63:5]) begin
						cmd.head = value[7:0];
					end else if (&value[63:7]) begin
						cmd.head    = mpe_pkg::FMT_INT8;
						cmd.nbytes  = 4'd1;
						cmd.payload = {value[7:0], 56'd0};
					end else if (&value[63:15]) begin
						cmd.head    = mpe_pkg::FMT_INT16;
						cmd.nbytes  = 4'd2;
						cmd.payload = {value[15:0], 48'd0};
					end else if (&value[63:31]) begin
						cmd.head    = mpe_pkg::FMT_INT32;
						cmd.nbytes  = 4'd4;
						cmd.payload = {value[31:0], 32'd0};
					end else begin
						cmd.head    = mpe_pkg::FMT_INT64;
						cmd.nbytes  = 4'd8;
						cmd.payload = value;
					end
				end else begin
					if (value[63:7] == 57'd0) begin
						cmd.head = value[7:0];
					end else if (value[63:8] == 56'd0) begin
						cmd.head    = mpe_pkg::FMT_UINT8;
						cmd.nbytes  = 4'd1;
						cmd.payload = {value[7:0], 56'd0};
					end else if (value[63:16] == 48'd0) begin
						cmd.head    = mpe_pkg::FMT_UINT16;
						cmd.nbytes  = 4'd2;
						cmd.payload = {value[15:0], 48'd0};
					end else if (value[63:32] == 32'd0) begin
						cmd.head    = mpe_pkg::FMT_UINT32;
						cmd.nbytes  = 4'd4;
						cmd.payload = {value[31:0], 32'd0};
					end else begin
						cmd.head    = mpe_pkg::FMT_UINT64;
						cmd.nbytes  = 4'd8;
						cmd.payload = value;
					end
				end
			end
			mpe_pkg::KIND_F32: begin
				cmd.head    = mpe_pkg::FMT_F32;
				cmd.nbytes  = 4'd4;
				cmd.payload = {value[31:0], 32'd0};
			end
			mpe_pkg::KIND_F64: begin
				cmd.head    = mpe_pkg::FMT_F64;
				cmd.nbytes  = 4'd8;
				cmd.payload = value;
			end
			mpe_pkg::KIND_STR: begin
				if (len[31:5] == 27'd0) begin
					cmd.head = {mpe_pkg::FIXSTR_BASE, len[4:0]};
				end else if (len[31:8] == 24'd0) begin
					cmd.head    = mpe_pkg::FMT_STR8;
					cmd.nbytes  = 4'd1;
					cmd.payload = {len[7:0], 56'd0};
				end else if (len[31:16] == 16'd0) begin
					cmd.head    = mpe_pkg::FMT_STR16;
					cmd.nbytes  = 4'd2;
					cmd.payload = {len[15:0], 48'd0};
				end else begin
					cmd.head    = mpe_pkg::FMT_STR32;
					cmd.nbytes  = 4'd4;
					cmd.payload = {len, 32'd0};
				end
			end
			mpe_pkg::KIND_ARRAY, mpe_pkg::KIND_MAP: begin
				if (len[31:4] == 28'd0) begin
					cmd.head = (kind == mpe_pkg::KIND_ARRAY) ?
						{mpe_pkg::FIXARR_BASE, len[3:0]} : {mpe_pkg::FIXMAP_BASE, len[3:0]};
				end else if (len[31:16] == 16'd0) begin
					cmd.head    = (kind == mpe_pkg::KIND_ARRAY) ?
						mpe_pkg::FMT_ARRAY16 : mpe_pkg::FMT_MAP16;
					cmd.nbytes  = 4'd2;
					cmd.payload = {len[15:0], 48'd0};
				end else begin
					cmd.head    = (kind == mpe_pkg::KIND_ARRAY) ?
						mpe_pkg::FMT_ARRAY32 : mpe_pkg::FMT_MAP32;
					cmd.nbytes  = 4'd4;
					cmd.payload = {len, 32'd0};
				end
			end
			mpe_pkg::KIND_RAW: begin
				cmd.head = value[7:0];
			end
			default: begin
				// Unused kinds are taken and dropped without output.
				cmd_valid = 1'b0;
			end
		endcase
	end

endmodule

@@ rtl/core/mpe_queue.sv @@
// ----------------------------------------------------------------------------
// mpe_queue
// Small first-in first-out queue of encoding jobs between front and back.
// ----------------------------------------------------------------------------
module mpe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mpe_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output mpe_pkg::cmd_t pop_cmd
);

	mpe_pkg::cmd_t                  entry_q [mpe_pkg::QDEPTH];
	logic [mpe_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [mpe_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [mpe_pkg::QCNT_W-1:0]     count_q;
	logic                           do_push;
	logic                           do_pop;

	assign full    = (count_q == mpe_pkg::QCNT_W'(mpe_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/mpe_back.sv @@
// ----------------------------------------------------------------------------
// mpe_back
// Serialises queued jobs into bytes, format byte first, then the payload
// most significant byte first, into a registered output stage.
// ----------------------------------------------------------------------------
module mpe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  mpe_pkg::cmd_t q_cmd,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tlast
);

	logic [63:0] data_q;
	logic [3:0]  rem_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        advance;
	logic        busy;

	assign advance  = !out_valid_q || m_tready;
	assign busy     = (rem_q != 4'd0);
	assign q_pop    = advance && !busy && !q_empty;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			if (busy) begin
				out_byte_q <= data_q[63:56];
				out_last_q <= (rem_q == 4'd1);
				data_q     <= {data_q[55:0], 8'd0};
			end else if (!q_empty) begin
				out_byte_q <= q_cmd.head;
				out_last_q <= (q_cmd.nbytes == 4'd0);
				data_q     <= q_cmd.payload;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			if (busy) begin
				rem_q       <= rem_q - 4'd1;
				out_valid_q <= 1'b1;
			end else if (!q_empty) begin
				rem_q       <= q_cmd.nbytes;
				out_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ verif/msgpack_value_encoder_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msgpack_value_encoder_core_test
// Self-checking bench for the MessagePack value encoder.
// ----------------------------------------------------------------------------
// A queue of typed values feeds the slave stream. Each accepted value is
// encoded here into the bytes it must produce. Every output beat is checked
// against the oldest outstanding byte and its last flag. Directed values cover
// every kind and the edges between integer and header forms. Random values
// cluster around those edges. Both streams idle at random, and the sender
// sometimes waits until the output has fully drained.
// ----------------------------------------------------------------------------
module msgpack_value_encoder_core_test;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 380;
	localparam int TAIL_CYCLES  = 20;

	localparam logic [63:0] FORM_EDGES [8] = '{
		64'h0f, 64'h1f, 64'h7f, 64'hff, 64'h7fff, 64'hffff, 64'h7fff_ffff, 64'hffff_ffff
	};

	typedef struct {
		logic [7:0] code;
		logic       last;
	} wire_byte_t;

	typedef struct {
		logic [3:0]  kind;
		logic [63:0] value;
		logic        drain;
	} value_item_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata  = '0;
	logic [3:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	wire_byte_t  wire_bytes_due[$];
	value_item_t values_to_send[$];
	value_item_t next_value;

	int          send_gap     = 0;
	int          stall_left   = 0;
	int          cycles       = 0;
	logic        quiet        = 1'b0;
	int          errors       = 0;
	int          values_taken = 0;
	int          ignored      = 0;
	int          bytes_seen   = 0;
	int          drains       = 0;

	msgpack_value_encoder_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void push_encoding(logic [7:0] head, int nb, logic [63:0] v);
		wire_byte_t b;
		b.code = head;
		b.last = (nb == 0);
		wire_bytes_due.push_back(b);
		for (int i = nb - 1; i >= 0; i--) begin
			b.code = v[8*i +: 8];
			b.last = (i == 0);
			wire_bytes_due.push_back(b);
		end
	endfunction

	function automatic void encode_uint(logic [63:0] v);
		if (v <= 64'h7f)
			push_encoding(v[7:0], 0, '0);
		else if (v <= 64'hff)
			push_encoding(mpe_pkg::FMT_UINT8, 1, v);
		else if (v <= 64'hffff)
			push_encoding(mpe_pkg::FMT_UINT16, 2, v);
		else if (v <= 64'hffff_ffff)
			push_encoding(mpe_pkg::FMT_UINT32, 4, v);
		else
			push_encoding(mpe_pkg::FMT_UINT64, 8, v);
	endfunction

	function automatic void encode_int(logic [63:0] v);
		if (!v[63])
			encode_uint(v);
		else if (v >= 64'hffff_ffff_ffff_ffe0)
			push_encoding(v[7:0], 0, '0);
		else if (v >= 64'hffff_ffff_ffff_ff80)
			push_encoding(mpe_pkg::FMT_INT8, 1, v);
		else if (v >= 64'hffff_ffff_ffff_8000)
			push_encoding(mpe_pkg::FMT_INT16, 2, v);
		else if (v >= 64'hffff_ffff_8000_0000)
			push_encoding(mpe_pkg::FMT_INT32, 4, v);
		else
			push_encoding(mpe_pkg::FMT_INT64, 8, v);
	endfunction

	// Lengths and counts wrap to 32 bits before the form is chosen.
	function automatic void encode_header(logic [63:0] v, logic [7:0] fix_head,
			logic [7:0] fix_max, logic allow8, logic [7:0] code16, logic [7:0] code32);
		logic [63:0] n;
		n = {32'd0, v[31:0]};
		if (n <= {56'd0, fix_max})
			push_encoding(fix_head | n[7:0], 0, '0);
		else if (allow8 && n <= 64'hff)
			push_encoding(mpe_pkg::FMT_STR8, 1, n);
		else if (n <= 64'hffff)
			push_encoding(code16, 2, n);
		else
			push_encoding(code32, 4, n);
	endfunction

	function automatic void encode_value(logic [3:0] kind, logic [63:0] v);
		case (kind)
			mpe_pkg::KIND_NIL:   push_encoding(mpe_pkg::FMT_NIL, 0, '0);
			mpe_pkg::KIND_BOOL:  push_encoding((v != 0) ? mpe_pkg::FMT_TRUE :
					mpe_pkg::FMT_FALSE, 0, '0);
			mpe_pkg::KIND_UINT:  encode_uint(v);
			mpe_pkg::KIND_INT:   encode_int(v);
			mpe_pkg::KIND_F32:   push_encoding(mpe_pkg::FMT_F32, 4, v);
			mpe_pkg::KIND_F64:   push_encoding(mpe_pkg::FMT_F64, 8, v);
			mpe_pkg::KIND_STR:   encode_header(v, {mpe_pkg::FIXSTR_BASE, 5'd0}, 8'h1f, 1'b1,
					mpe_pkg::FMT_STR16, mpe_pkg::FMT_STR32);
			mpe_pkg::KIND_ARRAY: encode_header(v, {mpe_pkg::FIXARR_BASE, 4'd0}, 8'h0f, 1'b0,
					mpe_pkg::FMT_ARRAY16, mpe_pkg::FMT_ARRAY32);
			mpe_pkg::KIND_MAP:   encode_header(v, {mpe_pkg::FIXMAP_BASE, 4'd0}, 8'h0f, 1'b0,
					mpe_pkg::FMT_MAP16, mpe_pkg::FMT_MAP32);
			mpe_pkg::KIND_RAW:   push_encoding(v[7:0], 0, '0);
			default:    ;
		endcase
	endfunction

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		logic [63:0] mask;
		v    = {$urandom(), $urandom()};
		mask = (64'd1 << $urandom_range(0, 64)) - 64'd1;
		case ($urandom_range(0, 3))
			0: ;
			1: v = v & mask;
			2: begin
				v = FORM_EDGES[$urandom_range(0, 7)] + 64'($urandom_range(0, 2)) - 64'd1;
				if ($urandom_range(0, 1) == 1)
					v = ~v;
			end
			default: v = ~(v & mask);
		endcase
		return v;
	endfunction

	function automatic void queue_value(logic [3:0] kind, logic [63:0] v);
		value_item_t it;
		it.kind  = kind;
		it.value = v;
		it.drain = 1'b0;
		values_to_send.push_back(it);
	endfunction

	function automatic void queue_drain();
		value_item_t it;
		it.kind  = '0;
		it.value = '0;
		it.drain = 1'b1;
		values_to_send.push_back(it);
	endfunction

	// A drain marker is only retired once the previous beat has left the bus,
	// so the monitor has already booked its bytes.
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (values_to_send.size() != 0 && values_to_send[0].drain) begin
				s_tvalid <= 1'b0;
				if (!s_tvalid && wire_bytes_due.size() == 0) begin
					void'(values_to_send.pop_front());
					drains <= drains + 1;
				end
			end else if (send_gap != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (values_to_send.size() != 0) begin
				next_value = values_to_send.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= next_value.kind;
				s_tdata  <= next_value.value;
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (arst_n && pick_gap() != 0 && $urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				encode_value(s_tuser, s_tdata);
				values_taken <= values_taken + 1;
				if (s_tuser > mpe_pkg::KIND_RAW)
					ignored <= ignored + 1;
			end
			if (m_tvalid && m_tready) begin
				bytes_seen <= bytes_seen + 1;
				if (wire_bytes_due.size() == 0) begin
					$display("%0t: unexpected byte: expected none, actual %02h last %0b",
						$time, m_tdata, m_tlast);
					errors <= errors + 1;
				end else begin
					if (m_tdata !== wire_bytes_due[0].code) begin
						$display("%0t: byte mismatch: expected %02h, actual %02h",
							$time, wire_bytes_due[0].code, m_tdata);
						errors <= errors + 1;
					end
					if (m_tlast !== wire_bytes_due[0].last) begin
						$display("%0t: last flag mismatch: expected %0b, actual %0b",
							$time, wire_bytes_due[0].last, m_tlast);
						errors <= errors + 1;
					end
					void'(wire_bytes_due.pop_front());
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 64 == 0)
			quiet <= ($urandom_range(0, 3) == 0);
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d bytes outstanding", $time,
				wire_bytes_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int count;
		int len;
		int r;

		queue_value(mpe_pkg::KIND_NIL, 64'd0);
		queue_value(mpe_pkg::KIND_BOOL, 64'd0);
		queue_value(mpe_pkg::KIND_BOOL, 64'h8000_0000_0000_0000);
		queue_value(mpe_pkg::KIND_UINT, 64'h7f);
		queue_value(mpe_pkg::KIND_UINT, 64'h80);
		queue_value(mpe_pkg::KIND_UINT, '1);
		queue_value(mpe_pkg::KIND_INT, -64'sd32);
		queue_value(mpe_pkg::KIND_INT, -64'sd33);
		queue_value(mpe_pkg::KIND_INT, 64'h8000_0000_0000_0000);
		queue_value(mpe_pkg::KIND_INT, 64'h7fff_ffff_ffff_ffff);
		queue_value(mpe_pkg::KIND_F32, '1);
		queue_value(mpe_pkg::KIND_F64, 64'h0123_4567_89ab_cdef);
		queue_value(mpe_pkg::KIND_STR, 64'd31);
		queue_value(mpe_pkg::KIND_STR, 64'd32);
		queue_value(mpe_pkg::KIND_STR, 64'h1_0000_0000);
		queue_value(mpe_pkg::KIND_STR, 64'hffff_ffff);
		queue_value(mpe_pkg::KIND_ARRAY, 64'd15);
		queue_value(mpe_pkg::KIND_ARRAY, 64'd16);
		queue_value(mpe_pkg::KIND_MAP, 64'h1_0001_0000);
		queue_value(mpe_pkg::KIND_MAP, 64'hffff);
		queue_value(mpe_pkg::KIND_RAW, '1);
		queue_value(4'd10, 64'd5);
		queue_value(4'd15, '1);
		queue_drain();

		// Mostly single values; some strings followed by their payload bytes.
		count = 0;
		while (count < RANDOM_ITEMS) begin
			if (count % 120 == 60)
				queue_drain();
			r = $urandom_range(0, 99);
			if (r < 10) begin
				len = $urandom_range(0, 5);
				queue_value(mpe_pkg::KIND_STR, 64'(len));
				repeat (len)
					queue_value(mpe_pkg::KIND_RAW, {$urandom(), $urandom()});
				count += len + 1;
			end else if (r < 15) begin
				queue_value(4'($urandom_range(10, 15)), rand_value());
				count++;
			end else begin
				queue_value(4'($urandom_range(0, 9)), rand_value());
				count++;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (values_to_send.size() != 0 || s_tvalid)
			@(negedge clk);
		while (wire_bytes_due.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Encoded %0d values (%0d of unused kinds) into %0d checked bytes,",
			values_taken, ignored, bytes_seen);
		$display("with %0d full drains of the output and %0d errors.", drains, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/mpe_pkg.sv
rtl/core/mpe_front.sv
rtl/core/mpe_queue.sv
rtl/core/mpe_back.sv
rtl/core/msgpack_value_encoder_core.sv
verif/msgpack_value_encoder_core_test.sv
